// File: rtl/rpj_pkg.sv
// Shared constants, widths and register codes for the disparity reprojection block.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps
`default_nettype none

package rpj_pkg;

    localparam int COORD_BITS = 12;

    localparam int DISP_W = 16;
    localparam int CFG_W  = 16;
    localparam int Z_W    = 24;
    localparam int XY_W   = 32;

    // Magnitude of (pos*16 - center) and the dividend width of the three dividers.
    localparam int MAG_W  = (COORD_BITS + 4 > CFG_W) ? COORD_BITS + 4 : CFG_W;
    localparam int NUM_W  = MAG_W + 1;
    localparam int DVD_W  = MAG_W + Z_W;
    localparam int DVS_W  = CFG_W;
    localparam int ZT_W   = 2 * COORD_BITS + 1;
    localparam int TAG_W  = (ZT_W > Z_W + 3) ? ZT_W : Z_W + 3;

    // One whole pixel of disparity in Q.4.
    localparam logic signed [DISP_W-1:0] DISP_MIN_Q4 = 16'sd16;

    localparam int ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_FOCAL_X   = 3'd0,
        REG_FOCAL_Y   = 3'd1,
        REG_CENTER_X  = 3'd2,
        REG_CENTER_Y  = 3'd3,
        REG_BASELINE  = 3'd4,
        REG_MAX_DEPTH = 3'd5
    } reg_idx_t;

    localparam logic [CFG_W-1:0] FOCAL_X_RST   = 16'd8000;
    localparam logic [CFG_W-1:0] FOCAL_Y_RST   = 16'd8000;
    localparam logic [CFG_W-1:0] CENTER_X_RST  = 16'd5120;
    localparam logic [CFG_W-1:0] CENTER_Y_RST  = 16'd3840;
    localparam logic [CFG_W-1:0] BASELINE_RST  = 16'd256;
    localparam logic [CFG_W-1:0] MAX_DEPTH_RST = 16'd3000;

endpackage

`default_nettype wire

// File: rtl/rpj_div.sv
// Pipelined restoring divider, one quotient bit per register stage, with a side tag.
// Depends on rpj_pkg for the dividend, divisor and tag widths.
`timescale 1ns / 1ps
`default_nettype none

module rpj_div (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     en,
    input  wire logic                     in_vld,
    input  wire logic [rpj_pkg::DVD_W-1:0] dvd,
    input  wire logic [rpj_pkg::DVS_W-1:0] dvs,
    input  wire logic [rpj_pkg::TAG_W-1:0] tag_in,
    output logic                          out_vld,
    output logic [rpj_pkg::DVD_W-1:0]     quo,
    output logic [rpj_pkg::TAG_W-1:0]     tag_out
);
    import rpj_pkg::*;

    localparam int WW = DVS_W + DVD_W;

    logic [WW-1:0]    work_reg [0:DVD_W-1];
    logic [DVS_W-1:0] dvs_reg  [0:DVD_W-1];
    logic [TAG_W-1:0] tag_reg  [0:DVD_W-1];
    logic [DVD_W-1:0] vld_reg;

    // The partial remainder sits above the dividend; quotient bits fill in from the bottom.
    for (genvar i = 0; i < DVD_W; i++) begin : g_stage
        logic [WW-1:0]    cur;
        logic [DVS_W-1:0] cur_dvs;
        logic [TAG_W-1:0] cur_tag;
        logic             cur_vld;
        logic [DVS_W:0]   trial;
        logic [DVS_W:0]   diff;
        logic [WW-1:0]    work_next;

        if (i == 0) begin : g_first
            assign cur     = {{DVS_W{1'b0}}, dvd};
            assign cur_dvs = dvs;
            assign cur_tag = tag_in;
            assign cur_vld = in_vld;
        end
        else begin : g_rest
            assign cur     = work_reg[i-1];
            assign cur_dvs = dvs_reg[i-1];
            assign cur_tag = tag_reg[i-1];
            assign cur_vld = vld_reg[i-1];
        end

        always_comb
        begin
            trial = cur[WW-1:DVD_W-1];
            diff  = trial - {1'b0, cur_dvs};
            if (!diff[DVS_W])
            begin
                work_next = {diff[DVS_W-1:0], cur[DVD_W-2:0], 1'b1};
            end
            else
            begin
                work_next = {trial[DVS_W-1:0], cur[DVD_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= cur_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                work_reg[i] <= work_next;
                dvs_reg[i]  <= cur_dvs;
                tag_reg[i]  <= cur_tag;
            end
        end
    end

    assign out_vld = vld_reg[DVD_W-1];
    assign quo     = work_reg[DVD_W-1][DVD_W-1:0];
    assign tag_out = tag_reg[DVD_W-1];

endmodule

`default_nettype wire

// File: rtl/disparity_to_point_reprojection.sv
// Top level of the stereo disparity to 3-D point reprojection pipeline.
// Depends on rpj_pkg and rpj_div (three instances: depth, lateral, vertical).
//
//  Channel | Direction | Handshake             | Contents
//  s_axis  | in        | tvalid/tready         | disparity_q4, col, row
//  m_axis  | out       | tvalid/tready         | point_x, point_y, point_z; tuser point_valid
//  apb     | in        | psel/penable/pready   | six 16-bit registers at 4*i
//
// One pixel is accepted every cycle unless the output stalls. The pipeline has one stage
// for the focal*baseline product, DVD_W divider stages for depth, two stages for the
// coordinate offsets and their products with depth, DVD_W divider stages for X and Y
// in parallel, and the output register.
// Reset clears every valid bit and loads the register reset values.
// When the output transfer is stalled the whole pipeline holds, so nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module disparity_to_point_reprojection (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // [15:0] disparity_q4, [27:16] col, [39:28] row
    input  wire logic [39:0]                 s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // [31:0] point_x, [63:32] point_y, [87:64] point_z
    output logic [87:0]                      m_axis_tdata,
    // [0] point_valid
    output logic                             m_axis_tuser,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rpj_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import rpj_pkg::*;

    localparam logic [DVD_W-1:0] SAT_POS = DVD_W'(32'h7FFF_FFFF);
    localparam logic [DVD_W-1:0] SAT_NEG = DVD_W'(32'h8000_0000);

    // Configuration registers, read directly by every stage. Writes must arrive only while
    // the pipeline is empty; the block itself does not enforce this.
    logic [CFG_W-1:0] focal_x_reg, focal_y_reg, center_x_reg, center_y_reg;
    logic [CFG_W-1:0] baseline_reg, max_depth_reg;
    reg_idx_t         cfg_idx;
    logic             cfg_wr;
    logic [CFG_W-1:0] cfg_rd;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg   <= FOCAL_X_RST;
            focal_y_reg   <= FOCAL_Y_RST;
            center_x_reg  <= CENTER_X_RST;
            center_y_reg  <= CENTER_Y_RST;
            baseline_reg  <= BASELINE_RST;
            max_depth_reg <= MAX_DEPTH_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_FOCAL_X:   focal_x_reg   <= pwdata[CFG_W-1:0];
                REG_FOCAL_Y:   focal_y_reg   <= pwdata[CFG_W-1:0];
                REG_CENTER_X:  center_x_reg  <= pwdata[CFG_W-1:0];
                REG_CENTER_Y:  center_y_reg  <= pwdata[CFG_W-1:0];
                REG_BASELINE:  baseline_reg  <= pwdata[CFG_W-1:0];
                REG_MAX_DEPTH: max_depth_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_FOCAL_X:   cfg_rd = focal_x_reg;
            REG_FOCAL_Y:   cfg_rd = focal_y_reg;
            REG_CENTER_X:  cfg_rd = center_x_reg;
            REG_CENTER_Y:  cfg_rd = center_y_reg;
            REG_BASELINE:  cfg_rd = baseline_reg;
            REG_MAX_DEPTH: cfg_rd = max_depth_reg;
            default:       cfg_rd = '0;
        endcase
    end

    assign prdata = {{(32 - CFG_W){1'b0}}, cfg_rd};

    // The pipeline advances as a whole whenever the output register is free or
    // being emptied in this cycle.
    logic en;
    logic out_vld_reg;

    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    // Stage 1: disparity check and the focal*baseline product.
    logic signed [DISP_W-1:0] in_disp;
    logic [COORD_BITS-1:0]    in_col, in_row;
    logic                     s1_vld_reg, s1_ok_reg;
    logic [2*CFG_W-1:0]       s1_prod_reg;
    logic [DVS_W-1:0]         s1_dvs_reg;
    logic [COORD_BITS-1:0]    s1_col_reg, s1_row_reg;

    assign in_disp = $signed(s_axis_tdata[15:0]);
    assign in_col  = s_axis_tdata[16 +: COORD_BITS];
    assign in_row  = s_axis_tdata[28 +: COORD_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ok_reg   <= in_disp > DISP_MIN_Q4;
            s1_prod_reg <= focal_x_reg * baseline_reg;
            s1_dvs_reg  <= in_disp[DVS_W-1:0];
            s1_col_reg  <= in_col;
            s1_row_reg  <= in_row;
        end
    end

    // Depth divider: Z = focal_x * baseline / disparity.
    logic             zd_vld;
    logic [DVD_W-1:0] zd_quo;
    logic [TAG_W-1:0] zd_tag;

    rpj_div u_zdiv (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (s1_vld_reg),
        .dvd     (DVD_W'(s1_prod_reg)),
        .dvs     (s1_dvs_reg),
        .tag_in  (TAG_W'({s1_ok_reg, s1_col_reg, s1_row_reg})),
        .out_vld (zd_vld),
        .quo     (zd_quo),
        .tag_out (zd_tag)
    );

    // Stage 2: depth range check and signed offsets from the principal point.
    logic                    z_ok;
    logic [COORD_BITS-1:0]   z_col, z_row;
    logic signed [NUM_W-1:0] numx, numy;
    logic [NUM_W-1:0]        absx, absy;
    logic                    s2_vld_reg, s2_ok_reg, s2_negx_reg, s2_negy_reg;
    logic [Z_W-1:0]          s2_z_reg;
    logic [MAG_W-1:0]        s2_magx_reg, s2_magy_reg;

    assign z_col = zd_tag[COORD_BITS +: COORD_BITS];
    assign z_row = zd_tag[COORD_BITS-1:0];
    assign z_ok  = zd_tag[ZT_W-1] && (zd_quo != '0)
                   && (zd_quo < DVD_W'({max_depth_reg, 8'h00}));
    assign numx  = $signed(NUM_W'({z_col, 4'h0})) - $signed(NUM_W'(center_x_reg));
    assign numy  = $signed(NUM_W'({z_row, 4'h0})) - $signed(NUM_W'(center_y_reg));
    assign absx  = numx[NUM_W-1] ? NUM_W'(-numx) : NUM_W'(numx);
    assign absy  = numy[NUM_W-1] ? NUM_W'(-numy) : NUM_W'(numy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_vld_reg <= zd_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_ok_reg   <= z_ok;
            s2_z_reg    <= zd_quo[Z_W-1:0];
            s2_negx_reg <= numx[NUM_W-1];
            s2_negy_reg <= numy[NUM_W-1];
            s2_magx_reg <= absx[MAG_W-1:0];
            s2_magy_reg <= absy[MAG_W-1:0];
        end
    end

    // Stage 3: offset magnitudes times depth.
    logic             s3_vld_reg, s3_ok_reg, s3_negx_reg, s3_negy_reg;
    logic             s3_zerox_reg, s3_zeroy_reg;
    logic [Z_W-1:0]   s3_z_reg;
    logic [DVD_W-1:0] s3_prodx_reg, s3_prody_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_ok_reg    <= s2_ok_reg;
            s3_z_reg     <= s2_z_reg;
            s3_negx_reg  <= s2_negx_reg;
            s3_negy_reg  <= s2_negy_reg;
            s3_zerox_reg <= (s2_magx_reg == '0);
            s3_zeroy_reg <= (s2_magy_reg == '0);
            s3_prodx_reg <= s2_magx_reg * s2_z_reg;
            s3_prody_reg <= s2_magy_reg * s2_z_reg;
        end
    end

    // Lateral and vertical dividers run side by side on the same enable.
    logic             xd_vld, yd_vld;
    logic [DVD_W-1:0] xd_quo, yd_quo;
    logic [TAG_W-1:0] xd_tag, yd_tag;

    rpj_div u_xdiv (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (s3_vld_reg),
        .dvd     (s3_prodx_reg),
        .dvs     (focal_x_reg),
        .tag_in  (TAG_W'({s3_ok_reg, s3_negx_reg, s3_zerox_reg, s3_z_reg})),
        .out_vld (xd_vld),
        .quo     (xd_quo),
        .tag_out (xd_tag)
    );

    rpj_div u_ydiv (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (s3_vld_reg),
        .dvd     (s3_prody_reg),
        .dvs     (focal_y_reg),
        .tag_in  (TAG_W'({s3_negy_reg, s3_zeroy_reg})),
        .out_vld (yd_vld),
        .quo     (yd_quo),
        .tag_out (yd_tag)
    );

    // Sign, saturation and the zero-divisor case, applied to an unsigned quotient.
    function automatic logic [XY_W-1:0] sat_coord(
        input logic [DVD_W-1:0] q,
        input logic             neg,
        input logic             zero,
        input logic             div0
    );
        logic [XY_W-1:0] res;
        if (zero)
        begin
            res = '0;
        end
        else if (div0)
        begin
            res = neg ? SAT_NEG[XY_W-1:0] : SAT_POS[XY_W-1:0];
        end
        else if (neg)
        begin
            res = (q > SAT_NEG) ? SAT_NEG[XY_W-1:0] : XY_W'(-q[XY_W-1:0]);
        end
        else
        begin
            res = (q > SAT_POS) ? SAT_POS[XY_W-1:0] : q[XY_W-1:0];
        end
        return res;
    endfunction

    // Stage 4: output register. An item that failed either check leaves as zeros.
    logic            o_ok;
    logic [XY_W-1:0] x_next, y_next;
    logic [Z_W-1:0]  z_next;
    logic [XY_W-1:0] out_x_reg, out_y_reg;
    logic [Z_W-1:0]  out_z_reg;
    logic            out_pv_reg;

    assign o_ok   = xd_tag[Z_W+2];
    assign x_next = o_ok ? sat_coord(xd_quo, xd_tag[Z_W+1], xd_tag[Z_W], focal_x_reg == '0)
                         : '0;
    assign y_next = o_ok ? sat_coord(yd_quo, yd_tag[1], yd_tag[0], focal_y_reg == '0)
                         : '0;
    assign z_next = o_ok ? xd_tag[Z_W-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= xd_vld && yd_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_x_reg  <= x_next;
            out_y_reg  <= y_next;
            out_z_reg  <= z_next;
            out_pv_reg <= o_ok;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {out_z_reg, out_y_reg, out_x_reg};
    assign m_axis_tuser  = out_pv_reg;

`ifndef SYNTHESIS
    // The input side is ready exactly when the output register can move.
    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not track the output register");

    // A rejected point leaves as all zeros.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("invalid point carries nonzero coordinates");

    // A valid point has a depth strictly inside the configured range.
    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (out_z_reg != '0) && (out_z_reg < {max_depth_reg, 8'h00}))
        else $error("valid point has depth outside range");

    // The two coordinate dividers stay in lockstep.
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        xd_vld == yd_vld)
        else $error("lateral and vertical dividers out of step");
`endif

endmodule

`default_nettype wire

// File: verif/disparity_to_point_reprojection_tb.sv
// Self-checking testbench for the disparity to 3-D point reprojection block.
// Depends on rpj_pkg and the disparity_to_point_reprojection RTL.
// A behavioral predictor computes the expected point for every pixel transfer.
`timescale 1ns / 1ps

module disparity_to_point_reprojection_tb;
    import rpj_pkg::*;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [23:0]        pz;
        logic               pv;
    } point_t;

    localparam int LATENCY = 2 * DVD_W + 4;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow copy of the configuration registers.
    logic [15:0] cfg_fx, cfg_fy, cfg_cx, cfg_cy, cfg_base, cfg_maxd;

    point_t      pending_points[$];
    int          mismatches;
    int          points_checked;
    int          cycles;
    int          valid_points;
    bit          no_idle;

    disparity_to_point_reprojection u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // The cycle counter guards against a hung handshake.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // Offset of a pixel from the principal point times depth, divided by the
    // focal length with truncation toward zero, then clamped to 32 bits. A zero
    // focal length saturates toward the sign of the numerator.
    function automatic logic signed [31:0] project_axis(input logic [11:0] pos,
            input logic [15:0] center, input longint z, input logic [15:0] focal);
        longint num;
        longint q;
        begin
            num = (longint'(pos) * 16 - longint'(center)) * z;
            if (focal == 16'd0)
                q = (num > 0) ? 64'sd2147483647 : (num < 0) ? -64'sd2147483648 : 0;
            else
            begin
                q = num / longint'(focal);
                if (q > 64'sd2147483647) q = 64'sd2147483647;
                if (q < -64'sd2147483648) q = -64'sd2147483648;
            end
            return q[31:0];
        end
    endfunction

    function automatic point_t reproject(input logic signed [15:0] disp,
            input logic [11:0] col, input logic [11:0] row);
        point_t  p;
        longint  z;
        longint  zlim;
        begin
            p = '0;
            if (disp > DISP_MIN_Q4)
            begin
                z = (longint'(cfg_fx) * longint'(cfg_base)) / longint'(disp);
                zlim = longint'(cfg_maxd) * 256;
                if (z > 0 && z < zlim)
                begin
                    p.px = project_axis(col, cfg_cx, z, cfg_fx);
                    p.py = project_axis(row, cfg_cy, z, cfg_fy);
                    p.pz = z[23:0];
                    p.pv = 1'b1;
                end
            end
            return p;
        end
    endfunction

    function automatic bit idle_now();
        return !no_idle && ($urandom_range(99) < 18);
    endfunction

    // Sends one pixel; the prediction is queued when the transfer happens.
    // The valid line is left high so that the next pixel can follow directly.
    task automatic send_pixel(input logic signed [15:0] disp, input logic [11:0] col,
            input logic [11:0] row);
        begin
            while (idle_now())
            begin
                s_axis_tvalid <= 1'b0;
                @(negedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= {row, col, disp};
            @(posedge clk);
            while (!s_axis_tready) @(posedge clk);
            pending_points.push_back(reproject(disp, col, row));
            @(negedge clk);
        end
    endtask

    // Waits for every expected point, then lets the pipeline drain fully.
    task automatic drain();
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
            while (pending_points.size() != 0) @(negedge clk);
            repeat (LATENCY + 8) @(negedge clk);
        end
    endtask

    // One APB write: setup cycle, then access cycle.
    task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
        begin
            psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
            paddr <= ADDR_W'(4 * int'(idx)); pwdata <= {16'd0, value};
            @(negedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready) @(posedge clk);
            @(negedge clk);
            case (idx)
                REG_FOCAL_X:   cfg_fx = value;
                REG_FOCAL_Y:   cfg_fy = value;
                REG_CENTER_X:  cfg_cx = value;
                REG_CENTER_Y:  cfg_cy = value;
                REG_BASELINE:  cfg_base = value;
                default:       cfg_maxd = value;
            endcase
        end
    endtask

    task automatic write_all(input logic [15:0] fx, input logic [15:0] fy,
            input logic [15:0] cx, input logic [15:0] cy, input logic [15:0] bl,
            input logic [15:0] md);
        begin
            drain();
            write_reg(REG_FOCAL_X, fx);
            write_reg(REG_FOCAL_Y, fy);
            write_reg(REG_CENTER_X, cx);
            write_reg(REG_CENTER_Y, cy);
            write_reg(REG_BASELINE, bl);
            write_reg(REG_MAX_DEPTH, md);
            psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        end
    endtask

    // Picks a disparity that usually lands in the valid depth range.
    function automatic logic signed [15:0] rand_disp();
        int r;
        begin
            r = $urandom_range(99);
            if (r < 10) return 16'($urandom);
            if (r < 15) return 16'(int'($urandom_range(20)) - 4);
            if (r < 20) return 16'(32767 - int'($urandom_range(200)));
            return 16'(int'($urandom_range(4000)) + 17);
        end
    endfunction

    // Output side: random back-pressure and the field-by-field point check.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= !idle_now();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            point_t want;
            point_t got;
            got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[87:64],
                   m_axis_tuser};
            if (pending_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected point transfer x=%0d y=%0d z=%0d v=%0b",
                             got.px, got.py, got.pz, got.pv);
            end
            else
            begin
                want = pending_points.pop_front();
                points_checked++;
                if (want.pv) valid_points++;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Point mismatch: expected x=%0d y=%0d z=%0d v=%0b, got x=%0d y=%0d z=%0d v=%0b",
                                 want.px, want.py, want.pz, want.pv,
                                 got.px, got.py, got.pz, got.pv);
                end
            end
        end
    end

    task automatic test_directed_edges();
        begin
            send_pixel(16'sd16, 12'd0, 12'd0);
            send_pixel(16'sd17, 12'd0, 12'd0);
            send_pixel(16'sd0, 12'd100, 12'd100);
            send_pixel(-16'sd1, 12'd100, 12'd100);
            send_pixel(-16'sd32768, 12'd4095, 12'd4095);
            send_pixel(16'sd32767, 12'd4095, 12'd4095);
            send_pixel(16'sd32767, 12'd0, 12'd0);
            send_pixel(16'sd800, 12'd320, 12'd240);
            send_pixel(16'sd700, 12'd4095, 12'd0);
            send_pixel(16'sd700, 12'd0, 12'd4095);
            send_pixel(16'sd2000, 12'hAAA, 12'h555);
            send_pixel(16'sd2000, 12'h555, 12'hAAA);
        end
    endtask

    // Extreme settings: zero and full-scale registers exercise the depth check
    // and the zero vertical focal length saturation.
    task automatic test_extreme_config();
        begin
            write_all(16'd65535, 16'd0, 16'd0, 16'd65535, 16'd65535, 16'd65535);
            send_pixel(16'sd17, 12'd4095, 12'd0);
            send_pixel(16'sd32767, 12'd4095, 12'd4095);
            send_pixel(16'sd5000, 12'd0, 12'd0);
            send_pixel(16'sd9000, 12'd1, 12'd1);
            write_all(16'd1, 16'd1, 16'd65535, 16'd0, 16'd1, 16'd1);
            send_pixel(16'sd17, 12'd0, 12'd4095);
            send_pixel(16'sd17, 12'd4095, 12'd4095);
            write_all(16'd0, 16'd8000, 16'd5120, 16'd3840, 16'd256, 16'd3000);
            send_pixel(16'sd100, 12'd10, 12'd10);
            write_all(16'd8000, 16'd8000, 16'd5120, 16'd3840, 16'd0, 16'd3000);
            send_pixel(16'sd100, 12'd10, 12'd10);
            write_all(16'd8000, 16'd8000, 16'd5120, 16'd3840, 16'd256, 16'd0);
            send_pixel(16'sd100, 12'd10, 12'd10);
        end
    endtask

    task automatic test_random_pixels(input int count);
        begin
            for (int i = 0; i < count; i++)
            begin
                // One long stretch runs with no idling on either side.
                no_idle = (i >= count / 3) && (i < count / 3 + 150);
                send_pixel(rand_disp(), 12'($urandom), 12'($urandom));
            end
            no_idle = 1'b0;
        end
    endtask

    task automatic test_random_configs();
        begin
            for (int phase = 0; phase < 5; phase++)
            begin
                write_all(16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)),
                          16'($urandom), 16'($urandom),
                          16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)));
                test_random_pixels(250);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        cycles = 0; mismatches = 0; points_checked = 0; valid_points = 0;
        no_idle = 1'b0;
        cfg_fx = FOCAL_X_RST; cfg_fy = FOCAL_Y_RST;
        cfg_cx = CENTER_X_RST; cfg_cy = CENTER_Y_RST;
        cfg_base = BASELINE_RST; cfg_maxd = MAX_DEPTH_RST;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_edges();
        test_random_pixels(350);
        test_extreme_config();
        test_random_configs();
        drain();

        $display("Checked %0d point transfers (%0d valid) across default, extreme and",
                 points_checked, valid_points);
        $display("random camera settings with random stalls on both streams.");
        if (mismatches == 0 && pending_points.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/rpj_pkg.sv
rtl/rpj_div.sv
rtl/disparity_to_point_reprojection.sv
verif/disparity_to_point_reprojection_tb.sv
